/* hdl/ecgprc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ecgprc_pkg
// Shared types, register indexes and reset values for the ECG peak rate
// classifier.
// ----------------------------------------------------------------------------
package ecgprc_pkg;

	localparam int unsigned TIME_W = 32;
	localparam int unsigned AMP_W  = 16;
	localparam int unsigned LIM_W  = 16;
	localparam int unsigned CFG_W  = 16;
	localparam int unsigned IDX_W  = 2;

	// register indexes
	localparam logic [IDX_W-1:0] CFG_PEAK_THRESHOLD = 2'd0;
	localparam logic [IDX_W-1:0] CFG_SLOW_LIMIT     = 2'd1;
	localparam logic [IDX_W-1:0] CFG_FAST_LIMIT     = 2'd2;

	// reset values
	localparam logic signed [AMP_W-1:0] RST_PEAK_THRESHOLD = 16'sd410;
	localparam logic [LIM_W-1:0]        RST_SLOW_LIMIT     = 16'd1000;
	localparam logic [LIM_W-1:0]        RST_FAST_LIMIT     = 16'd600;

	// samples held before a peak can be judged
	localparam logic [1:0] HIST_FULL = 2'd2;

	typedef enum logic [1:0] {
		RC_NORMAL = 2'd0,
		RC_TACHY  = 2'd1,
		RC_BRADY  = 2'd2
	} rhythm_t;

	// peak pair handed from detection to classification
	typedef struct packed {
		logic              valid;
		logic [TIME_W-1:0] earlier;
		logic [TIME_W-1:0] later;
	} peak_word_t;

endpackage
`default_nettype wire

/* hdl/ecg_peak_rate_classifier_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ecg_peak_rate_classifier_unit
// R-peak detector and RR interval classifier for a timestamped ECG stream.
// ----------------------------------------------------------------------------
// One sample word is taken per clock unless the input stalls. A word in the
// input register completes the test of the newer held sample against its two
// neighbours; any peak pair it yields is registered in the result register.
// The peak test and 32-bit interval subtract and compare are combinational.
// A sample is a peak when it is strictly above peak_threshold (Q3.12) and
// strictly above both neighbours, so a peak is seen when the next sample
// arrives. Every peak after the first of a record yields one result: the
// previous and new peak times, their difference modulo 2^32, and a class
// (bradycardia when over slow_limit_ms, which wins, tachycardia when under
// fast_limit_ms, otherwise normal). first_sample restarts the record. The
// input stalls only while a result waits in the output register and the
// next word would produce another. Configuration is written through
// cfg_wr_en, cfg_index and cfg_wdata; the user must write it only while the
// block is idle, which the block does not enforce. Other indexes are ignored.
// ----------------------------------------------------------------------------
module ecg_peak_rate_classifier_unit (
	input  wire                                  clk,
	input  wire                                  arst_n,
	// configuration
	input  wire                                  cfg_wr_en,
	input  wire        [ecgprc_pkg::IDX_W-1:0]   cfg_index,
	input  wire        [ecgprc_pkg::CFG_W-1:0]   cfg_wdata,
	// sample words
	input  wire                                  in_valid,
	output logic                                 in_ready,
	input  wire                                  first_sample,
	input  wire        [ecgprc_pkg::TIME_W-1:0]  sample_time,
	input  wire signed [ecgprc_pkg::AMP_W-1:0]   sample_amplitude,
	// result words
	output logic                                 out_valid,
	input  wire                                  out_ready,
	output logic       [1:0]                     rhythm_class,
	output logic       [ecgprc_pkg::TIME_W-1:0]  earlier_peak_time,
	output logic       [ecgprc_pkg::TIME_W-1:0]  later_peak_time,
	output logic       [ecgprc_pkg::TIME_W-1:0]  interval_ms
);

	// configuration registers
	logic signed [ecgprc_pkg::AMP_W-1:0] peak_threshold_q;
	logic [ecgprc_pkg::LIM_W-1:0]        slow_limit_q;
	logic [ecgprc_pkg::LIM_W-1:0]        fast_limit_q;

	ecgprc_pkg::peak_word_t peak;
	logic                   slot_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_threshold_q <= ecgprc_pkg::RST_PEAK_THRESHOLD;
			slow_limit_q     <= ecgprc_pkg::RST_SLOW_LIMIT;
			fast_limit_q     <= ecgprc_pkg::RST_FAST_LIMIT;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				ecgprc_pkg::CFG_PEAK_THRESHOLD: begin
					peak_threshold_q <= $signed(cfg_wdata[ecgprc_pkg::AMP_W-1:0]);
				end
				ecgprc_pkg::CFG_SLOW_LIMIT: begin
					slow_limit_q <= cfg_wdata[ecgprc_pkg::LIM_W-1:0];
				end
				ecgprc_pkg::CFG_FAST_LIMIT: begin
					fast_limit_q <= cfg_wdata[ecgprc_pkg::LIM_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// history, peak test, stall control
	ecgprc_detect u_detect (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.first_sample     (first_sample),
		.sample_time      (sample_time),
		.sample_amplitude (sample_amplitude),
		.peak_threshold   (peak_threshold_q),
		.slot_free        (slot_free),
		.peak             (peak)
	);

	// interval, class, result register
	ecgprc_classify u_classify (
		.clk               (clk),
		.arst_n            (arst_n),
		.peak              (peak),
		.slow_limit_ms     (slow_limit_q),
		.fast_limit_ms     (fast_limit_q),
		.slot_free         (slot_free),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.rhythm_class      (rhythm_class),
		.earlier_peak_time (earlier_peak_time),
		.later_peak_time   (later_peak_time),
		.interval_ms       (interval_ms)
	);

endmodule
`default_nettype wire

/* hdl/ecgprc_detect.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ecgprc_detect
// Input register, sample history and three-point peak test.
// ----------------------------------------------------------------------------
module ecgprc_detect (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   in_valid,
	output logic                                  in_ready,
	input  wire                                   first_sample,
	input  wire        [ecgprc_pkg::TIME_W-1:0]   sample_time,
	input  wire signed [ecgprc_pkg::AMP_W-1:0]    sample_amplitude,
	input  wire signed [ecgprc_pkg::AMP_W-1:0]    peak_threshold,
	input  wire                                   slot_free,
	output ecgprc_pkg::peak_word_t                peak
);

	// input register
	logic                                 s1_valid_s1;
	logic                                 first_s1;
	logic [ecgprc_pkg::TIME_W-1:0]        time_s1;
	logic signed [ecgprc_pkg::AMP_W-1:0]  amp_s1;

	// history
	logic signed [ecgprc_pkg::AMP_W-1:0]  older_amp_q;
	logic signed [ecgprc_pkg::AMP_W-1:0]  newer_amp_q;
	logic [ecgprc_pkg::TIME_W-1:0]        newer_time_q;
	logic [1:0]                           hist_q;
	logic                                 have_peak_q;
	logic [ecgprc_pkg::TIME_W-1:0]        last_peak_q;

	logic [1:0] hist_eff;
	logic       have_eff;
	logic       is_peak;
	logic       emit;
	logic       fire;

	always_comb begin
		hist_eff = first_s1 ? 2'd0 : hist_q;
		have_eff = first_s1 ? 1'b0 : have_peak_q;
		is_peak  = (hist_eff == ecgprc_pkg::HIST_FULL) &&
		           (newer_amp_q > peak_threshold) &&
		           (newer_amp_q > older_amp_q) &&
		           (newer_amp_q > amp_s1);
		emit     = s1_valid_s1 && is_peak && have_eff;
		fire     = s1_valid_s1 && (!emit || slot_free);
		in_ready = !s1_valid_s1 || fire;

		peak.valid   = emit && slot_free;
		peak.earlier = last_peak_q;
		peak.later   = newer_time_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (in_ready) begin
			s1_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			first_s1 <= first_sample;
			time_s1  <= sample_time;
			amp_s1   <= sample_amplitude;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			older_amp_q  <= '0;
			newer_amp_q  <= '0;
			newer_time_q <= '0;
			hist_q       <= '0;
			have_peak_q  <= 1'b0;
			last_peak_q  <= '0;
		end else if (fire) begin
			older_amp_q  <= first_s1 ? '0 : newer_amp_q;
			newer_amp_q  <= amp_s1;
			newer_time_q <= time_s1;
			hist_q       <= (hist_eff == ecgprc_pkg::HIST_FULL) ? hist_eff : hist_eff + 2'd1;
			if (is_peak) begin
				have_peak_q <= 1'b1;
				last_peak_q <= newer_time_q;
			end else begin
				have_peak_q <= have_eff;
				last_peak_q <= first_s1 ? '0 : last_peak_q;
			end
		end
	end

	// history never counts past two samples
	a_hist_range: assert property (@(posedge clk) disable iff (!arst_n)
		hist_q != 2'd3) else $error("sample history count out of range");

	// a peak pair only leaves while the word it comes from is retired
	a_peak_fire: assert property (@(posedge clk) disable iff (!arst_n)
		peak.valid |-> fire && have_eff) else $error("peak issued without retiring word");

	// a held word blocks the input only while a peak waits for the output slot
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> emit && !slot_free) else $error("input stalled without cause");

endmodule
`default_nettype wire

/* hdl/ecgprc_classify.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ecgprc_classify
// Interval subtraction, limit compare and result register.
// ----------------------------------------------------------------------------
module ecgprc_classify (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire  ecgprc_pkg::peak_word_t        peak,
	input  wire  [ecgprc_pkg::LIM_W-1:0]        slow_limit_ms,
	input  wire  [ecgprc_pkg::LIM_W-1:0]        fast_limit_ms,
	output logic                                slot_free,
	output logic                                out_valid,
	input  wire                                 out_ready,
	output logic [1:0]                          rhythm_class,
	output logic [ecgprc_pkg::TIME_W-1:0]       earlier_peak_time,
	output logic [ecgprc_pkg::TIME_W-1:0]       later_peak_time,
	output logic [ecgprc_pkg::TIME_W-1:0]       interval_ms
);

	logic [ecgprc_pkg::TIME_W-1:0] iv;
	ecgprc_pkg::rhythm_t           cls;
	logic                          out_valid_q;

	always_comb begin
		iv = peak.later - peak.earlier;
		if (iv > {{(ecgprc_pkg::TIME_W-ecgprc_pkg::LIM_W){1'b0}}, slow_limit_ms}) begin
			cls = ecgprc_pkg::RC_BRADY;
		end else if (iv < {{(ecgprc_pkg::TIME_W-ecgprc_pkg::LIM_W){1'b0}}, fast_limit_ms}) begin
			cls = ecgprc_pkg::RC_TACHY;
		end else begin
			cls = ecgprc_pkg::RC_NORMAL;
		end
		slot_free = !out_valid_q || out_ready;
		out_valid = out_valid_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (slot_free) begin
			out_valid_q <= peak.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (slot_free && peak.valid) begin
			rhythm_class      <= cls;
			earlier_peak_time <= peak.earlier;
			later_peak_time   <= peak.later;
			interval_ms       <= iv;
		end
	end

	// the held interval always matches its two peak times
	a_iv_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> interval_ms == later_peak_time - earlier_peak_time)
		else $error("interval does not match peak times");

	// no unused class code ever leaves
	a_class_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> rhythm_class != 2'd3) else $error("bad rhythm class code");

	// a new pair is offered only into a free slot
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		peak.valid |-> slot_free) else $error("result overwritten");

endmodule
`default_nettype wire
